>>> rtl/core/amg_soc_pkg.sv
// Package for the AMG strength-of-connection core: widths, register indexes, packed entry type.
// No dependencies.
`timescale 1ns / 1ps
package amg_soc_pkg;
  localparam int RowMaxDefault = 32;
  localparam int ThrW = 20;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 20;
  localparam logic [CfgIdxW-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_ABS_MODE = 1'b1;
  localparam int InW = 56;
  localparam int OutW = 56;

  // one buffered matrix entry handed from the front to the back
  typedef struct packed {
    logic [15:0] col;
    logic signed [31:0] val;
    logic [7:0] fn;
    logic last;
  } entry_t;
endpackage

>>> rtl/core/amg_soc_front.sv
// Front end: accepts matrix entries and pushes them into a small queue.
// Depends on amg_soc_pkg.
`timescale 1ns / 1ps
module amg_soc_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  amg_soc_pkg::entry_t    in_entry,
  output logic                   q_valid,
  input  logic                   q_ready,
  output amg_soc_pkg::entry_t    q_entry
);
  import amg_soc_pkg::*;
  // two-entry queue, pointer based
  entry_t q_mem [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic push, pop;

  assign in_ready = (fill != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (fill != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_entry = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr] <= in_entry;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

>>> rtl/core/amg_soc_back.sv
// Back end: buffers a row, forms the scale, then rescans and emits strong columns and a row-end item.
// Depends on amg_soc_pkg.
`timescale 1ns / 1ps
module amg_soc_back #(
  parameter int ROW_MAX = amg_soc_pkg::RowMaxDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  output logic                             q_ready,
  input  amg_soc_pkg::entry_t              q_entry,
  input  logic [amg_soc_pkg::ThrW-1:0]     threshold,
  input  logic                             abs_mode,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [amg_soc_pkg::OutW-1:0]     out_data,
  output logic                             out_user,
  output logic                             out_last
);
  import amg_soc_pkg::*;
  localparam int IdxW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
  localparam int CntW = $clog2(ROW_MAX + 1);

  typedef enum logic [4:0] {
    S_LOAD  = 5'b00001,
    S_SCALE = 5'b00010,
    S_MUL   = 5'b00100,
    S_EMIT  = 5'b01000,
    S_END   = 5'b10000
  } state_t;
  state_t state;

  logic [15:0] col_mem [ROW_MAX];
  logic signed [31:0] val_mem [ROW_MAX];
  logic [7:0] fn_mem [ROW_MAX];

  logic [CntW-1:0] entry_count;
  logic overflow_flag;
  logic diagonal_negative;
  logic [7:0] row_function;
  logic signed [32:0] scale_acc;
  logic signed [53:0] bound;
  logic [31:0] strong_total;
  logic [5:0] strong_count;
  logic [CntW-1:0] scan;
  logic [IdxW-1:0] scan_idx;
  logic rd_valid;
  logic [15:0] rd_col;
  logic signed [31:0] rd_val;
  logic [7:0] rd_fn;
  logic obuf_full;
  logic can_out;

  assign scan_idx = scan[IdxW-1:0];
  assign q_ready = (state == S_LOAD);
  assign out_valid = obuf_full;
  assign can_out = !obuf_full || out_ready;

  // buffer memory write and registered read; the read holds while emission stalls
  always_ff @(posedge clk) begin
    if (q_valid && q_ready && entry_count < CntW'(ROW_MAX)) begin
      col_mem[entry_count[IdxW-1:0]] <= q_entry.col;
      val_mem[entry_count[IdxW-1:0]] <= q_entry.val;
      fn_mem[entry_count[IdxW-1:0]] <= q_entry.fn;
    end
    if (state != S_EMIT || can_out) begin
      rd_col <= col_mem[scan_idx];
      rd_val <= val_mem[scan_idx];
      rd_fn <= fn_mem[scan_idx];
    end
  end

  // per-entry classification of the read data
  logic signed [32:0] v_ext, v_mag, scale_cand;
  logic match, bigger, smaller, is_strong;
  logic signed [53:0] v_shift;
  always_comb begin
    v_ext = {rd_val[31], rd_val};
    v_mag = rd_val[31] ? -v_ext : v_ext;
    match = (rd_fn == row_function);
    scale_cand = abs_mode ? v_mag : v_ext;
    bigger = scale_cand > scale_acc;
    smaller = scale_cand < scale_acc;
    v_shift = {{5{scale_cand[32]}}, scale_cand, 16'd0};
    if (abs_mode || diagonal_negative) is_strong = v_shift > bound;
    else is_strong = v_shift < bound;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      entry_count <= '0;
      overflow_flag <= 1'b0;
      diagonal_negative <= 1'b0;
      row_function <= '0;
      scale_acc <= '0;
      strong_total <= '0;
      strong_count <= '0;
      scan <= '0;
      rd_valid <= 1'b0;
      obuf_full <= 1'b0;
      bound <= '0;
    end else begin
      if (obuf_full && out_ready) obuf_full <= 1'b0;
      case (state)
        S_LOAD: begin
          if (q_valid) begin
            if (entry_count == '0) begin
              row_function <= q_entry.fn;
              diagonal_negative <= q_entry.val[31];
            end
            if (entry_count < CntW'(ROW_MAX)) entry_count <= entry_count + 1'b1;
            else overflow_flag <= 1'b1;
            if (q_entry.last) begin
              state <= S_SCALE;
              scan <= CntW'(1);
              rd_valid <= 1'b0;
              scale_acc <= '0;
            end
          end
        end
        S_SCALE: begin
          // address issued this cycle, data checked next
          rd_valid <= (scan < entry_count);
          if (scan < entry_count) scan <= scan + 1'b1;
          if (rd_valid && match) begin
            if ((abs_mode || diagonal_negative) ? bigger : smaller) scale_acc <= scale_cand;
          end
          if (rd_valid && !(scan < entry_count)) state <= S_MUL;
          else if (!rd_valid && !(scan < entry_count)) state <= S_MUL;
        end
        S_MUL: begin
          bound <= $signed({1'b0, threshold}) * scale_acc;
          scan <= CntW'(1);
          rd_valid <= 1'b0;
          strong_count <= '0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (can_out) begin
            rd_valid <= (scan < entry_count);
            if (scan < entry_count) scan <= scan + 1'b1;
            if (rd_valid && match && is_strong) begin
              out_data <= {40'd0, rd_col};
              out_user <= 1'b1;
              out_last <= 1'b0;
              obuf_full <= 1'b1;
              strong_count <= strong_count + 1'b1;
            end
            if (!(scan < entry_count)) state <= S_END;
          end
        end
        S_END: begin
          if (can_out) begin
            if (rd_valid && match && is_strong) begin
              out_data <= {40'd0, rd_col};
              out_user <= 1'b1;
              out_last <= 1'b0;
              obuf_full <= 1'b1;
              strong_count <= strong_count + 1'b1;
              rd_valid <= 1'b0;
            end else begin
              // row-end item: col 0, count, start, overflow
              out_data <= {1'b0, overflow_flag, strong_total, strong_count, 16'd0};
              out_user <= 1'b0;
              out_last <= 1'b1;
              obuf_full <= 1'b1;
              strong_total <= strong_total + {26'd0, strong_count};
              entry_count <= '0;
              overflow_flag <= 1'b0;
              state <= S_LOAD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

>>> rtl/core/amg_strength_of_connection_core.sv
// Top level of the AMG strength-of-connection core: config registers, front queue, back engine.
// Depends on amg_soc_pkg, amg_soc_front, amg_soc_back.
`timescale 1ns / 1ps
// Channel   Direction  Contents
// s_axis    in         tdata: column_index, entry_value, column_function; tlast: row_last
// m_axis    out        tdata: strong_column, strong_count, row_start, row_overflow;
//                      tuser: entry_valid; tlast: row_end
// cfg       in         cfg_we, cfg_index, cfg_data
// Each row is buffered up to ROW_MAX entries; at row end the engine scans the buffer for
// the scale, forms the threshold product, rescans through one memory read port for
// emission and then sends the row-end item; only then does it accept the next row.
// Reset is synchronous; clears control state.
// Either side may stall; a two-entry queue decouples input from the row engine.
module amg_strength_of_connection_core #(
  parameter int ROW_MAX = amg_soc_pkg::RowMaxDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [15:0] column_index, [47:16] entry_value, [55:48] column_function
  input  logic [amg_soc_pkg::InW-1:0]    s_axis_tdata,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [15:0] strong_column, [21:16] strong_count, [53:22] row_start, [54] row_overflow
  output logic [amg_soc_pkg::OutW-1:0]   m_axis_tdata,
  // [0] entry_valid
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast,
  input  logic                           cfg_we,
  input  logic [amg_soc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [amg_soc_pkg::CfgDataW-1:0] cfg_data
);
  import amg_soc_pkg::*;
  logic [ThrW-1:0] threshold;
  logic abs_mode;
  entry_t in_entry, q_entry;
  logic q_valid, q_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= ThrW'(16384);
      abs_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: threshold <= cfg_data[ThrW-1:0];
        REG_ABS_MODE: abs_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_entry = '{col: s_axis_tdata[15:0], val: s_axis_tdata[47:16],
                      fn: s_axis_tdata[55:48], last: s_axis_tlast};

  amg_soc_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_entry(in_entry), .q_valid(q_valid), .q_ready(q_ready), .q_entry(q_entry)
  );

  amg_soc_back #(.ROW_MAX(ROW_MAX)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_entry(q_entry),
    .threshold(threshold), .abs_mode(abs_mode), .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready), .out_data(m_axis_tdata), .out_user(m_axis_tuser),
    .out_last(m_axis_tlast)
  );

  // a row-end result never carries entry_valid
  a_end_shape: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser)
    else $error("row-end item malformed");
  // strong entries always carry entry_valid
  a_strong_shape: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser)
    else $error("strong item malformed");
endmodule
